/* sv/chm_pkg.sv */
// Shared constants, codes, types and helpers of the chained hash map engine.
package chm_pkg;

    localparam int MAX_ITEMS     = 1024;
    localparam int MAX_BUCKETS   = 2048;
    // Growth keeps the bucket count a power of two, so bucket select is a mask.
    localparam int FIRST_BUCKETS = 16;

    localparam int ITEM_W  = $clog2(MAX_ITEMS + 1);
    localparam int NODE_AW = $clog2(MAX_ITEMS);
    localparam int BKT_AW  = $clog2(MAX_BUCKETS);
    localparam int BKT_W   = $clog2(MAX_BUCKETS + 1);
    localparam int KEY_W   = 32;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;

    localparam logic [ITEM_W-1:0] EMPTY_MARK = ITEM_W'(MAX_ITEMS);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_GET     = 3'd2,
        CMD_RESTART = 3'd3,
        CMD_NEXT    = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_CLR,
        S_GR_HEAD,
        S_GR_HDAT,
        S_GR_NDAT,
        S_GR_WLO,
        S_GR_WHI,
        S_ADD_RD,
        S_ADD_WR,
        S_GET_HDAT,
        S_GET_NDAT,
        S_NX_LINK,
        S_NX_SCAN,
        S_NX_HDAT,
        S_NX_OUT,
        S_RESP
    } t_state;

    // Bucket head memory access
    typedef struct packed {
        logic              we;
        logic [BKT_AW-1:0] waddr;
        logic [ITEM_W-1:0] wdata;
        logic [BKT_AW-1:0] raddr;
    } t_head_req;

    // Node pool access: key/content share one write enable, link has its own
    typedef struct packed {
        logic               rec_we;
        logic               link_we;
        logic [NODE_AW-1:0] waddr;
        logic [KEY_W-1:0]   key;
        logic [KEY_W-1:0]   content;
        logic [ITEM_W-1:0]  link;
        logic [NODE_AW-1:0] raddr;
    } t_node_req;

    function automatic logic node_ok(input logic [ITEM_W-1:0] n);
        return n < ITEM_W'(MAX_ITEMS);
    endfunction

endpackage

/* sv/chm_ifs.sv */
// Valid/ready channel interfaces for commands and responses.
interface chm_cmd_if;
    import chm_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] content;

    modport source(output valid, output command, output key, output content, input ready);
    modport sink(input valid, input command, input key, input content, output ready);
endinterface

interface chm_rsp_if;
    import chm_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  value;
    logic [ITEM_W-1:0] entries;

    modport source(output valid, output status, output value, output entries, input ready);
    modport sink(input valid, input status, input value, input entries, output ready);
endinterface

/* sv/chained_hash_map_engine_top.sv */
// Top level of the chained hash map engine: sequencer plus head and node memories.
//
//  channel   dir  handshake          payload
//  i_cmd     in   valid/ready        command, key, content
//  o_rsp     out  valid/ready        status, value, entries
//
// One command at a time; i_cmd.ready is high only while the sequencer is idle.
// Clear, restart and unused codes go straight to the response; add reads the
// key's bucket head, then writes the node and the new head. Get misses at once
// on a bucketless table, else walks the key's chain until the key matches or
// the chain ends; next follows the current chain, then scans the heads past
// empty buckets. A growing add first marks the first table's heads empty, or
// else splits every old bucket's chain into its low and high halves.
// Reset is synchronous and needs no memory clearing pass. A stalled o_rsp holds
// its item in the output register while the next command is already taken.
module chained_hash_map_engine_top import chm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chm_cmd_if.sink   i_cmd,
    chm_rsp_if.source o_rsp
);
    t_head_req         head_req;
    t_node_req         node_req;
    logic [ITEM_W-1:0] head_rdata;
    logic [KEY_W-1:0]  key_rdata;
    logic [KEY_W-1:0]  content_rdata;
    logic [ITEM_W-1:0] link_rdata;

    // command sequencer
    chm_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_cmd),
        .o_rsp          (o_rsp),
        .o_head_req     (head_req),
        .i_head_rdata   (head_rdata),
        .o_node_req     (node_req),
        .i_key_rdata    (key_rdata),
        .i_content_rdata(content_rdata),
        .i_link_rdata   (link_rdata)
    );

    // bucket heads
    chm_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_BUCKETS)) u_head_ram (
        .i_clk  (i_clk),
        .i_we   (head_req.we),
        .i_waddr(head_req.waddr),
        .i_wdata(head_req.wdata),
        .i_raddr(head_req.raddr),
        .o_rdata(head_rdata)
    );

    // node pool
    chm_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS)) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (node_req.rec_we),
        .i_waddr(node_req.waddr),
        .i_wdata(node_req.key),
        .i_raddr(node_req.raddr),
        .o_rdata(key_rdata)
    );

    chm_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS)) u_content_ram (
        .i_clk  (i_clk),
        .i_we   (node_req.rec_we),
        .i_waddr(node_req.waddr),
        .i_wdata(node_req.content),
        .i_raddr(node_req.raddr),
        .o_rdata(content_rdata)
    );

    chm_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_ITEMS)) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (node_req.link_we),
        .i_waddr(node_req.waddr),
        .i_wdata(node_req.link),
        .i_raddr(node_req.raddr),
        .o_rdata(link_rdata)
    );
endmodule

/* sv/chm_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/chm_seq.sv */
// Command sequencer: chain walks, growth relinking and response buffer.
module chm_seq import chm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    chm_cmd_if.sink           i_cmd,
    chm_rsp_if.source         o_rsp,
    output t_head_req         o_head_req,
    input  logic [ITEM_W-1:0] i_head_rdata,
    output t_node_req         o_node_req,
    input  logic [KEY_W-1:0]  i_key_rdata,
    input  logic [KEY_W-1:0]  i_content_rdata,
    input  logic [ITEM_W-1:0] i_link_rdata
);
    t_state              r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [KEY_W-1:0]    r_content, n_content;
    logic [ITEM_W-1:0]   r_item_count, n_item_count;
    logic [BKT_W-1:0]    r_bucket_total, n_bucket_total;
    logic [BKT_W-1:0]    r_walk_bucket, n_walk_bucket;
    logic [ITEM_W-1:0]   r_walk_node, n_walk_node;
    logic [BKT_W-1:0]    r_new_total, n_new_total;
    logic [BKT_W-1:0]    r_b, n_b;
    logic [NODE_AW-1:0]  r_n, n_n;
    logic [ITEM_W-1:0]   r_lo, n_lo;
    logic [ITEM_W-1:0]   r_hi, n_hi;
    t_status             r_res_status, n_res_status;
    logic [KEY_W-1:0]    r_res_value, n_res_value;
    logic                r_out_valid, n_out_valid;
    logic [STAT_W-1:0]   r_out_status, n_out_status;
    logic [KEY_W-1:0]    r_out_value, n_out_value;
    logic [ITEM_W-1:0]   r_out_entries, n_out_entries;

    logic              accept;
    logic              out_free;
    logic              pool_full;
    logic              need_grow;
    logic [BKT_W:0]    dbl_count;
    logic [BKT_W-1:0]  grow_count;
    logic [BKT_AW-1:0] key_bkt;
    logic [BKT_AW-1:0] dst;
    logic              dst_lo;
    logic              wb_end;
    logic [BKT_W-1:0]  wb_inc;
    logic              wb_inc_end;
    logic              relink_last;
    logic              clr_last;
    logic              key_hit;

    // shared compare and index logic
    always_comb begin
        accept     = i_cmd.valid && (r_state == S_IDLE);
        out_free   = !r_out_valid || o_rsp.ready;
        pool_full  = r_item_count >= ITEM_W'(MAX_ITEMS);
        need_grow  = (r_bucket_total == '0)
                     || (BKT_W'(r_item_count) >= r_bucket_total);
        dbl_count  = (BKT_W+1)'(r_item_count) << 1;
        if (r_item_count == '0) begin
            grow_count = BKT_W'(FIRST_BUCKETS);
        end else if (dbl_count > (BKT_W+1)'(MAX_BUCKETS)) begin
            grow_count = BKT_W'(MAX_BUCKETS);
        end else begin
            grow_count = dbl_count[BKT_W-1:0];
        end
        key_bkt     = r_key[BKT_AW-1:0] & BKT_AW'(r_bucket_total - 1'b1);
        dst         = i_key_rdata[BKT_AW-1:0] & BKT_AW'(r_new_total - 1'b1);
        dst_lo      = dst == r_b[BKT_AW-1:0];
        wb_end      = r_walk_bucket >= r_bucket_total;
        wb_inc      = r_walk_bucket + 1'b1;
        wb_inc_end  = wb_inc >= r_bucket_total;
        relink_last = r_b == (r_bucket_total - 1'b1);
        clr_last    = r_b == (r_new_total - 1'b1);
        key_hit     = i_key_rdata == r_key;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (t_cmd'(r_cmd))
                    CMD_ADD: begin
                        if (pool_full) n_state = S_RESP;
                        else if (!need_grow) n_state = S_ADD_RD;
                        else if (r_bucket_total == '0) n_state = S_CLR;
                        else if (grow_count == r_bucket_total) n_state = S_ADD_RD;
                        else n_state = S_GR_HEAD;
                    end
                    CMD_GET: begin
                        n_state = (r_bucket_total == '0) ? S_RESP : S_GET_HDAT;
                    end
                    CMD_NEXT: begin
                        if (wb_end) n_state = S_RESP;
                        else if (node_ok(r_walk_node)) n_state = S_NX_LINK;
                        else n_state = S_NX_SCAN;
                    end
                    default: n_state = S_RESP;
                endcase
            end
            S_CLR: begin
                if (clr_last) n_state = S_ADD_RD;
            end
            S_GR_HEAD: n_state = S_GR_HDAT;
            S_GR_HDAT: n_state = node_ok(i_head_rdata) ? S_GR_NDAT : S_GR_WLO;
            S_GR_NDAT: n_state = node_ok(i_link_rdata) ? S_GR_NDAT : S_GR_WLO;
            S_GR_WLO:  n_state = S_GR_WHI;
            S_GR_WHI:  n_state = relink_last ? S_ADD_RD : S_GR_HEAD;
            S_ADD_RD:  n_state = S_ADD_WR;
            S_ADD_WR:  n_state = S_RESP;
            S_GET_HDAT: n_state = node_ok(i_head_rdata) ? S_GET_NDAT : S_RESP;
            S_GET_NDAT: begin
                if (key_hit || !node_ok(i_link_rdata)) n_state = S_RESP;
            end
            S_NX_LINK: begin
                if (node_ok(i_link_rdata)) n_state = S_NX_OUT;
                else if (wb_inc_end) n_state = S_RESP;
                else n_state = S_NX_SCAN;
            end
            S_NX_SCAN: n_state = S_NX_HDAT;
            S_NX_HDAT: begin
                if (node_ok(i_head_rdata)) n_state = S_NX_OUT;
                else if (wb_inc_end) n_state = S_RESP;
                else n_state = S_NX_SCAN;
            end
            S_NX_OUT: n_state = S_RESP;
            S_RESP: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath updates and memory requests
    always_comb begin
        n_cmd          = r_cmd;
        n_key          = r_key;
        n_content      = r_content;
        n_item_count   = r_item_count;
        n_bucket_total = r_bucket_total;
        n_walk_bucket  = r_walk_bucket;
        n_walk_node    = r_walk_node;
        n_new_total    = r_new_total;
        n_b            = r_b;
        n_n            = r_n;
        n_lo           = r_lo;
        n_hi           = r_hi;
        n_res_status   = r_res_status;
        n_res_value    = r_res_value;
        n_out_valid    = r_out_valid && !o_rsp.ready;
        n_out_status   = r_out_status;
        n_out_value    = r_out_value;
        n_out_entries  = r_out_entries;
        o_head_req     = '0;
        o_node_req     = '0;
        i_cmd.ready    = r_state == S_IDLE;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd     = i_cmd.command;
                    n_key     = i_cmd.key;
                    n_content = i_cmd.content;
                end
            end
            S_DISPATCH: begin
                n_res_status = ST_MISS;
                n_res_value  = '0;
                case (t_cmd'(r_cmd))
                    CMD_CLEAR: begin
                        n_item_count   = '0;
                        n_bucket_total = '0;
                        n_walk_bucket  = '0;
                        n_walk_node    = EMPTY_MARK;
                        n_res_status   = ST_OK;
                    end
                    CMD_ADD: begin
                        if (pool_full) begin
                            n_res_status = ST_FULL;
                        end
                        n_new_total = grow_count;
                        n_b         = '0;
                    end
                    CMD_GET: begin
                        o_head_req.raddr = key_bkt;
                    end
                    CMD_RESTART: begin
                        n_walk_bucket = '0;
                        n_walk_node   = EMPTY_MARK;
                        n_res_status  = ST_OK;
                    end
                    CMD_NEXT: begin
                        o_node_req.raddr = r_walk_node[NODE_AW-1:0];
                    end
                    default: begin
                        n_res_status = ST_MISS;
                    end
                endcase
            end
            // empty table: mark the first heads empty
            S_CLR: begin
                o_head_req.we    = 1'b1;
                o_head_req.waddr = r_b[BKT_AW-1:0];
                o_head_req.wdata = EMPTY_MARK;
                n_b              = r_b + 1'b1;
                if (clr_last) n_bucket_total = r_new_total;
            end
            S_GR_HEAD: begin
                o_head_req.raddr = r_b[BKT_AW-1:0];
                n_lo             = EMPTY_MARK;
                n_hi             = EMPTY_MARK;
            end
            S_GR_HDAT: begin
                if (node_ok(i_head_rdata)) begin
                    o_node_req.raddr = i_head_rdata[NODE_AW-1:0];
                    n_n              = i_head_rdata[NODE_AW-1:0];
                end
            end
            // push the node onto the low or high half of the split bucket
            S_GR_NDAT: begin
                o_node_req.link_we = 1'b1;
                o_node_req.waddr   = r_n;
                o_node_req.link    = dst_lo ? r_lo : r_hi;
                if (dst_lo) n_lo = ITEM_W'(r_n);
                else n_hi = ITEM_W'(r_n);
                if (node_ok(i_link_rdata)) begin
                    o_node_req.raddr = i_link_rdata[NODE_AW-1:0];
                    n_n              = i_link_rdata[NODE_AW-1:0];
                end
            end
            S_GR_WLO: begin
                o_head_req.we    = 1'b1;
                o_head_req.waddr = r_b[BKT_AW-1:0];
                o_head_req.wdata = r_lo;
            end
            S_GR_WHI: begin
                o_head_req.we    = 1'b1;
                o_head_req.waddr = BKT_AW'(r_b + r_bucket_total);
                o_head_req.wdata = r_hi;
                n_b              = r_b + 1'b1;
                if (relink_last) n_bucket_total = r_new_total;
            end
            S_ADD_RD: begin
                o_head_req.raddr = key_bkt;
            end
            S_ADD_WR: begin
                o_node_req.rec_we  = 1'b1;
                o_node_req.link_we = 1'b1;
                o_node_req.waddr   = r_item_count[NODE_AW-1:0];
                o_node_req.key     = r_key;
                o_node_req.content = r_content;
                o_node_req.link    = i_head_rdata;
                o_head_req.we      = 1'b1;
                o_head_req.waddr   = key_bkt;
                o_head_req.wdata   = r_item_count;
                n_item_count       = r_item_count + 1'b1;
                n_res_status       = ST_OK;
            end
            S_GET_HDAT: begin
                if (node_ok(i_head_rdata)) begin
                    o_node_req.raddr = i_head_rdata[NODE_AW-1:0];
                    n_n              = i_head_rdata[NODE_AW-1:0];
                end
            end
            S_GET_NDAT: begin
                if (key_hit) begin
                    n_res_status = ST_OK;
                    n_res_value  = i_content_rdata;
                end else if (node_ok(i_link_rdata)) begin
                    o_node_req.raddr = i_link_rdata[NODE_AW-1:0];
                    n_n              = i_link_rdata[NODE_AW-1:0];
                end
            end
            S_NX_LINK: begin
                if (node_ok(i_link_rdata)) begin
                    n_walk_node      = i_link_rdata;
                    o_node_req.raddr = i_link_rdata[NODE_AW-1:0];
                end else begin
                    n_walk_bucket = wb_inc;
                end
            end
            S_NX_SCAN: begin
                o_head_req.raddr = r_walk_bucket[BKT_AW-1:0];
            end
            S_NX_HDAT: begin
                n_walk_node = i_head_rdata;
                if (node_ok(i_head_rdata)) begin
                    o_node_req.raddr = i_head_rdata[NODE_AW-1:0];
                end else begin
                    n_walk_bucket = wb_inc;
                end
            end
            S_NX_OUT: begin
                n_res_status = ST_OK;
                n_res_value  = i_content_rdata;
            end
            // hand the item to the output register once it is free
            S_RESP: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_value   = r_res_value;
                    n_out_entries = r_item_count;
                end
            end
            default: begin
                n_res_status = r_res_status;
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_item_count   <= '0;
            r_bucket_total <= '0;
            r_walk_bucket  <= '0;
            r_walk_node    <= EMPTY_MARK;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_item_count   <= n_item_count;
            r_bucket_total <= n_bucket_total;
            r_walk_bucket  <= n_walk_bucket;
            r_walk_node    <= n_walk_node;
            r_out_valid    <= n_out_valid;
        end
        r_cmd         <= n_cmd;
        r_key         <= n_key;
        r_content     <= n_content;
        r_new_total   <= n_new_total;
        r_b           <= n_b;
        r_n           <= n_n;
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_res_status  <= n_res_status;
        r_res_value   <= n_res_value;
        r_out_status  <= n_out_status;
        r_out_value   <= n_out_value;
        r_out_entries <= n_out_entries;
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.status  = r_out_status;
    assign o_rsp.value   = r_out_value;
    assign o_rsp.entries = r_out_entries;
endmodule
